/* src/dmbtc_pkg.sv */
// Shared constants and request codes of the block tag cache engine.
`default_nettype none

package dmbtc_pkg;

  // field widths fixed by the channel formats
  localparam int BLOCK_W     = 24;
  localparam int COUNT_W     = 13;
  localparam int CFG_W       = 11;
  localparam int FIRST_W     = 10;
  localparam int FUNC_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // default sizing
  localparam int MAX_SLOTS_DEF = 1024;
  localparam int MAX_RUN_DEF   = 4096;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd256;

  // request kinds
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

endpackage

`default_nettype wire

/* src/direct_mapped_block_tag_cache.sv */
// Top level of the direct-mapped block tag cache engine.
//
// Request channel (in_*): in_tuser carries the request kind (lookup range,
// fill range, flush all); in_tdata carries first block and block count.
// Response channel (out_*): one response per request, all_present and
// first_slot in out_tdata. Config: cfg_wr_en/cfg_wr_data write slots_in_use
// (saturated to MAX_SLOTS, zero disables lookups and fills).
//
// Sequence: an enabled lookup or fill first runs its start block through
// the bit-serial modulo unit (24 steps, then a done strobe), then makes one
// tag store access per block of the run; a lookup that walks to the end of
// its run then passes a final compare state, and every request ends in the
// response state. A lookup stops after reading the first missing block.
// A flush sweeps all MAX_SLOTS entries, one per cycle, and then answers.
// Disabled or unused requests go straight to the response state. One request
// at a time; in_tready returns in the same cycle as the response is loaded.
// Reset: slots_in_use returns to 256 and the engine sweeps every tag store
// entry clearing every valid bit, in_tready low until it ends; config
// writes are taken during the sweep. Stall: the response waits in an
// output register; a new request is taken and parks until the register frees.
`default_nettype none

module direct_mapped_block_tag_cache #(
  parameter int MAX_SLOTS = dmbtc_pkg::MAX_SLOTS_DEF,
  parameter int MAX_RUN   = dmbtc_pkg::MAX_RUN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [23:0] first_blk, [36:24] block_count, [39:37] zero
  input  wire logic [dmbtc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  wire logic [dmbtc_pkg::FUNC_W-1:0]      in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] all_present, [10:1] first_slot, [15:11] zero
  output logic      [dmbtc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [dmbtc_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW     = $clog2(MAX_SLOTS + 1);
  localparam int CW     = $clog2(MAX_RUN + 1);
  localparam int TAG_W  = dmbtc_pkg::BLOCK_W + 1;   // valid bit on top of tag
  localparam int BW     = dmbtc_pkg::BLOCK_W;
  localparam int FW     = dmbtc_pkg::FIRST_W;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,   // sweeping valid bits (reset or flush)
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,   // start block modulo slot count
    ST_WALK  = 6'b001000,   // one slot per block of the run
    ST_LAST  = 6'b010000,   // final lookup compare
    ST_RESP  = 6'b100000    // waiting for the output register
  } state_t;

  state_t state_r, state_nxt;

  // ---- request fields ----
  logic [dmbtc_pkg::FUNC_W-1:0]  in_func;
  logic [BW-1:0]                 in_start;
  logic [dmbtc_pkg::COUNT_W-1:0] in_count;

  assign in_func  = in_tuser;
  assign in_start = in_tdata[BW-1:0];
  assign in_count = in_tdata[BW +: dmbtc_pkg::COUNT_W];

  // ---- slot count register ----
  logic [dmbtc_pkg::CFG_W-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= dmbtc_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // saturation of slot count and run length
  logic [NW-1:0] n_cfg;
  logic [CW-1:0] count_sat;

  always_comb begin
    if (32'(cfg_r) > 32'(MAX_SLOTS)) begin
      n_cfg = NW'(MAX_SLOTS);
    end else begin
      n_cfg = NW'(cfg_r);
    end
    if (32'(in_count) > 32'(MAX_RUN)) begin
      count_sat = CW'(MAX_RUN);
    end else begin
      count_sat = CW'(in_count);
    end
  end

  // ---- working registers ----
  logic              lookup_r, lookup_nxt;
  logic              flush_r, flush_nxt;
  logic [BW-1:0]     blk_r, blk_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CW-1:0]     run_r, run_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic              present_r, present_nxt;
  logic [FW-1:0]     first_r, first_nxt;
  logic [SLOT_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [BW-1:0]     chk_blk_r, chk_blk_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [dmbtc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // ---- modulo unit ----
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_rem;
  logic [31:0]   div_rem_ext;

  dmbtc_mod #(
    .NW (NW)
  ) u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (in_start),
    .divisor_i  (n_cfg),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign div_rem_ext = 32'(div_rem);

  // ---- tag store ----
  // Lookups only read and fills only write, so a read and a write never
  // meet on the same entry in one cycle: no forwarding path is needed.
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [TAG_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [TAG_W-1:0]  ram_rdata;

  dmbtc_tag_ram #(
    .DEPTH (MAX_SLOTS),
    .AW    (SLOT_W),
    .DW    (TAG_W)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (slot_r),
    .rd_data (ram_rdata)
  );

  // tag compare of the read issued last cycle
  logic miss;
  assign miss = chk_v_r && !(ram_rdata[TAG_W-1] && (ram_rdata[BW-1:0] == chk_blk_r));

  // next slot of the run: block number wraps at 2^24, slot wraps at n
  logic [SLOT_W-1:0] slot_step;
  always_comb begin
    if (blk_r == '1) begin
      slot_step = '0;
    end else if (32'(slot_r) + 32'd1 == 32'(n_r)) begin
      slot_step = '0;
    end else begin
      slot_step = slot_r + 1'b1;
    end
  end

  logic out_free;
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // ---- sequencer ----
  always_comb begin
    state_nxt      = state_r;
    lookup_nxt     = lookup_r;
    flush_nxt      = flush_r;
    blk_nxt        = blk_r;
    slot_nxt       = slot_r;
    run_nxt        = run_r;
    n_nxt          = n_r;
    present_nxt    = present_r;
    first_nxt      = first_r;
    clr_addr_nxt   = clr_addr_r;
    chk_v_nxt      = 1'b0;
    chk_blk_nxt    = chk_blk_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    div_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = {1'b1, blk_r};
    ram_re         = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == SLOT_W'(MAX_SLOTS - 1)) begin
          clr_addr_nxt = '0;
          flush_nxt    = 1'b0;
          state_nxt    = flush_r ? ST_RESP : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          blk_nxt     = in_start;
          run_nxt     = count_sat;
          n_nxt       = n_cfg;
          present_nxt = 1'b0;
          first_nxt   = '0;
          lookup_nxt  = (in_func == dmbtc_pkg::FUNC_LOOKUP);
          if (in_func == dmbtc_pkg::FUNC_FLUSH) begin
            flush_nxt    = 1'b1;
            clr_addr_nxt = '0;
            state_nxt    = ST_CLEAR;
          end else if ((in_func == dmbtc_pkg::FUNC_LOOKUP ||
                        in_func == dmbtc_pkg::FUNC_FILL) && n_cfg != '0) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          slot_nxt    = SLOT_W'(div_rem);
          first_nxt   = div_rem_ext[FW-1:0];
          present_nxt = lookup_r;
          state_nxt   = (run_r == '0) ? ST_RESP : ST_WALK;
        end
      end

      ST_WALK: begin
        if (lookup_r && miss) begin
          present_nxt = 1'b0;   // early out on the first absent block
          state_nxt   = ST_RESP;
        end else begin
          ram_we      = !lookup_r;
          ram_re      = lookup_r;
          chk_v_nxt   = lookup_r;
          chk_blk_nxt = blk_r;
          blk_nxt     = blk_r + 1'b1;
          slot_nxt    = slot_step;
          run_nxt     = run_r - 1'b1;
          if (run_r == CW'(1)) begin
            state_nxt = lookup_r ? ST_LAST : ST_RESP;
          end
        end
      end

      ST_LAST: begin
        if (miss) begin
          present_nxt = 1'b0;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {{(dmbtc_pkg::OUT_TDATA_W - FW - 1){1'b0}}, first_r, present_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      flush_r      <= 1'b0;
      clr_addr_r   <= '0;
      chk_v_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flush_r      <= flush_nxt;
      clr_addr_r   <= clr_addr_nxt;
      chk_v_r      <= chk_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lookup_r   <= lookup_nxt;
    blk_r      <= blk_nxt;
    slot_r     <= slot_nxt;
    run_r      <= run_nxt;
    n_r        <= n_nxt;
    present_r  <= present_nxt;
    first_r    <= first_nxt;
    chk_blk_r  <= chk_blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // ---- checks ----
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("tag store read and write in the same cycle");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> 32'(slot_r) < 32'(n_r))
    else $error("walk slot beyond slots in use");

  a_chk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> (state_r == ST_WALK || state_r == ST_LAST))
    else $error("tag compare pending outside the walk");

  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_RESP))
    else $error("response raised outside the response state");

  a_fill_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && !lookup_r |-> !present_r)
    else $error("fill carrying a hit flag");

endmodule

`default_nettype wire

/* src/dmbtc_mod.sv */
// Bit-serial restoring remainder unit: block number modulo slot count.
`default_nettype none

module dmbtc_mod #(
  parameter int NW = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start_i,
  input  wire logic [dmbtc_pkg::BLOCK_W-1:0] dividend_i,
  input  wire logic [NW-1:0]                 divisor_i,
  output logic                               done_o,
  output logic [NW-1:0]                      rem_o
);

  localparam int CNT_W = $clog2(dmbtc_pkg::BLOCK_W + 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [dmbtc_pkg::BLOCK_W-1:0] q_r, q_nxt;
  logic [NW-1:0]                 rem_r, rem_nxt;
  logic [NW-1:0]                 d_r, d_nxt;
  logic [NW:0]                   trial;

  // shift in one dividend bit, subtract the divisor where it fits
  always_comb begin
    trial    = {rem_r, q_r[dmbtc_pkg::BLOCK_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(dmbtc_pkg::BLOCK_W);
      q_nxt    = dividend_i;
      rem_nxt  = '0;
      d_nxt    = divisor_i;
    end else if (busy_r) begin
      q_nxt = {q_r[dmbtc_pkg::BLOCK_W-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = NW'(trial - {1'b0, d_r});
      end else begin
        rem_nxt = trial[NW-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

  // partial remainder stays below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (cnt_r != CNT_W'(dmbtc_pkg::BLOCK_W)) |-> rem_r < d_r)
    else $error("remainder not reduced below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("done without a division in flight");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !start_i |=> cnt_r == $past(cnt_r))
    else $error("step counter moved while idle");

endmodule

`default_nettype wire

/* src/dmbtc_tag_ram.sv */
// Slot tag store: one write port, one read port, registered read data.
`default_nettype none

module dmbtc_tag_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 25
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the direct-mapped block tag cache engine.
`default_nettype none

module tb;

  // Only three request kinds are defined. Code 3 must change nothing and
  // answer with zeros.
  localparam logic [dmbtc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [dmbtc_pkg::BLOCK_W-1:0] BLOCK_MASK = 24'hFFFFFF;
  localparam int N_PHASES = 12;
  localparam int PHASE_REQS = 146;

  typedef logic [dmbtc_pkg::BLOCK_W-1:0] blk_t;
  typedef logic [dmbtc_pkg::FIRST_W-1:0] first_t;
  typedef logic [dmbtc_pkg::CFG_W-1:0]   cfg_t;

  typedef struct packed {
    logic                          all_present;
    logic [dmbtc_pkg::FIRST_W-1:0] first_slot;
  } response_t;

  // One row of the directed table. When set_cfg is high, slots_in_use is
  // rewritten (with the engine idle) before the request goes out. When
  // fixed is high, the expected response is the typed-in one.
  typedef struct packed {
    logic                          set_cfg;
    logic [dmbtc_pkg::CFG_W-1:0]   cfg;
    logic [dmbtc_pkg::FUNC_W-1:0]  func;
    logic [dmbtc_pkg::BLOCK_W-1:0] start;
    logic [dmbtc_pkg::COUNT_W-1:0] count;
    logic                          fixed;
    logic                          exp_present;
    logic [dmbtc_pkg::FIRST_W-1:0] exp_first;
  } directed_row_t;

  typedef struct {
    logic [dmbtc_pkg::BLOCK_W-1:0] start;
    int unsigned                   count;
  } block_run_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // [23:0] first_blk, [36:24] block_count, [39:37] zero
  logic [dmbtc_pkg::IN_TDATA_W-1:0] in_tdata;
  logic [dmbtc_pkg::FUNC_W-1:0] in_tuser;       // [1:0] func
  logic out_tvalid;
  logic out_tready;
  // [0] all_present, [10:1] first_slot, [15:11] zero
  logic [dmbtc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en;
  logic [dmbtc_pkg::CFG_W-1:0] cfg_wr_data;

  direct_mapped_block_tag_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow of the tag store and of slots_in_use, kept in step with every
  // accepted request.
  logic [dmbtc_pkg::BLOCK_W-1:0] cached_tag [dmbtc_pkg::MAX_SLOTS_DEF];
  bit                            tag_valid  [dmbtc_pkg::MAX_SLOTS_DEF];
  logic [dmbtc_pkg::CFG_W-1:0]   slot_setting;

  response_t  pending_responses [$];
  block_run_t recent_fills [$];
  int errors;
  int in_idle_pct;
  int out_idle_pct;
  int tready_hold;   // cycles the receiver still has to hold off

  // Row 0 fills every one of the 1024 slots, so no tag is ever read before
  // it has been written, whatever the slot count later on.
  directed_row_t directed_rows [24] = '{
    '{1'b1, 11'd1024, dmbtc_pkg::FUNC_FILL,   24'h000000, 13'd1024, 1'b1, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'h000000, 13'd1024, 1'b1, 1'b1, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'h0003FF, 13'd1,    1'b1, 1'b1, 10'd1023},
    // empty run hits while enabled
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'h000000, 13'd0,    1'b1, 1'b1, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_FLUSH,  24'h000000, 13'd0,    1'b1, 1'b0, 10'd0},
    // block 0 must not look present after a flush
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'h000000, 13'd1,    1'b1, 1'b0, 10'd0},
    '{1'b0, 11'd0,    FUNC_UNUSED,            24'hFFFFFF, 13'd8191, 1'b1, 1'b0, 10'd0},
    // run past the top block wraps to block 0
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_FILL,   24'hFFFFFE, 13'd4,    1'b0, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'hFFFFFE, 13'd4,    1'b0, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_FILL,   24'h123456, 13'd0,    1'b0, 1'b0, 10'd0},
    // oversized run saturates to 4096 blocks
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_FILL,   24'h800000, 13'd8191, 1'b0, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'h800C00, 13'd1024, 1'b0, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'h800000, 13'd8191, 1'b0, 1'b0, 10'd0},
    // cache disabled: lookups miss, fills do nothing
    '{1'b1, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'h800C00, 13'd4,    1'b1, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_FILL,   24'h000005, 13'd2,    1'b1, 1'b0, 10'd0},
    // oversized slot count saturates to 1024
    '{1'b1, 11'd2047, dmbtc_pkg::FUNC_LOOKUP, 24'h800C00, 13'd1024, 1'b0, 1'b0, 10'd0},
    // flush still clears while disabled
    '{1'b1, 11'd0,    dmbtc_pkg::FUNC_FLUSH,  24'h000000, 13'd0,    1'b1, 1'b0, 10'd0},
    '{1'b1, 11'd1,    dmbtc_pkg::FUNC_FILL,   24'hFFFFFF, 13'd1,    1'b1, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'hFFFFFF, 13'd1,    1'b0, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'hFFFFFE, 13'd2,    1'b0, 1'b0, 10'd0},
    '{1'b1, 11'd1023, dmbtc_pkg::FUNC_FILL,   24'hABCDEF, 13'd3,    1'b0, 1'b0, 10'd0},
    '{1'b0, 11'd0,    dmbtc_pkg::FUNC_LOOKUP, 24'hABCDEF, 13'd3,    1'b0, 1'b0, 10'd0},
    '{1'b0, 11'd0,    FUNC_UNUSED,            24'h000000, 13'd0,    1'b1, 1'b0, 10'd0},
    '{1'b1, 11'd256,  dmbtc_pkg::FUNC_LOOKUP, 24'h000000, 13'd0,    1'b1, 1'b1, 10'd0}
  };

  // Works out the response to one request and applies its effect on the
  // shadow store.
  function automatic response_t predict_response(
      input logic [dmbtc_pkg::FUNC_W-1:0]  f,
      input logic [dmbtc_pkg::BLOCK_W-1:0] s,
      input logic [dmbtc_pkg::COUNT_W-1:0] c);
    response_t   r;
    int unsigned n;
    int unsigned run_len;
    int unsigned blk;
    int unsigned slot;
    r = '0;
    n = (slot_setting > dmbtc_pkg::MAX_SLOTS_DEF) ? dmbtc_pkg::MAX_SLOTS_DEF : slot_setting;
    run_len = (c > dmbtc_pkg::MAX_RUN_DEF) ? dmbtc_pkg::MAX_RUN_DEF : c;
    if (f == dmbtc_pkg::FUNC_FLUSH) begin
      for (int i = 0; i < dmbtc_pkg::MAX_SLOTS_DEF; i++) tag_valid[i] = 1'b0;
    end else if ((f == dmbtc_pkg::FUNC_LOOKUP || f == dmbtc_pkg::FUNC_FILL) && n != 0) begin
      r.first_slot = first_t'(s % n);
      r.all_present = (f == dmbtc_pkg::FUNC_LOOKUP);
      for (int unsigned i = 0; i < run_len; i++) begin
        blk = (s + i) & BLOCK_MASK;
        slot = blk % n;
        if (f == dmbtc_pkg::FUNC_FILL) begin
          cached_tag[slot] = blk_t'(blk);
          tag_valid[slot] = 1'b1;
        end else if (!tag_valid[slot] || cached_tag[slot] != blk) begin
          r.all_present = 1'b0;
          break;
        end
      end
    end
    return r;
  endfunction

  // Mostly short runs, some medium, a few at or beyond the saturation point.
  function automatic int unsigned pick_run_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 1) return $urandom_range(dmbtc_pkg::MAX_RUN_DEF, 8191);
    if (roll < 4) return $urandom_range(0, 600);
    return $urandom_range(0, 16);
  endfunction

  // Starts cluster in a window around a per-phase base so that slots collide
  // and runs overlap; some sit just below the top block to force wrapping.
  function automatic blk_t pick_first_blk(input blk_t base);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 99);
    span = (slot_setting == 0 || slot_setting > dmbtc_pkg::MAX_SLOTS_DEF) ?
           dmbtc_pkg::MAX_SLOTS_DEF : slot_setting;
    if (roll < 45) return blk_t'((base + $urandom_range(0, 2 * span + 32)) & BLOCK_MASK);
    if (roll < 55) return blk_t'(BLOCK_MASK - $urandom_range(0, 40));
    return blk_t'($urandom & BLOCK_MASK);
  endfunction

  // Offers one request, waits for it to be taken and files its expected
  // response. A request staying valid across two items is not dropped.
  task automatic issue_request(input logic [dmbtc_pkg::FUNC_W-1:0] f,
                               input logic [dmbtc_pkg::BLOCK_W-1:0] s,
                               input logic [dmbtc_pkg::COUNT_W-1:0] c, input bit fixed,
                               input response_t typed_in);
    response_t predicted;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {3'b000, c, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_response(f, s, c);
    pending_responses.push_back(fixed ? typed_in : predicted);
  endtask

  // Sender pauses until every outstanding response is back. Every request
  // answers once, so an empty queue means the engine is idle.
  task automatic wait_for_responses();
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [dmbtc_pkg::CFG_W-1:0] value);
    wait_for_responses();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slot_setting = value;
  endtask

  // Random requests under one slot count: fills and lookups dominate, and
  // many lookups revisit a recent fill so that hits actually occur.
  task automatic run_random_phase(input int n_reqs, input int hold_at);
    blk_t                         base;
    blk_t                         s;
    logic [dmbtc_pkg::FUNC_W-1:0] f;
    int unsigned                  c;
    int unsigned                  roll;
    int unsigned                  off;
    block_run_t                   pick;
    base = blk_t'($urandom & BLOCK_MASK);
    for (int k = 0; k < n_reqs; k++) begin
      if (k == hold_at) tready_hold = 400;
      roll = $urandom_range(0, 99);
      s = pick_first_blk(base);
      c = pick_run_length();
      if (roll < 2) begin
        f = dmbtc_pkg::FUNC_FLUSH;
      end else if (roll < 3) begin
        f = FUNC_UNUSED;
      end else if (roll < 45) begin
        f = dmbtc_pkg::FUNC_FILL;
        recent_fills.push_back('{s, (c > dmbtc_pkg::MAX_RUN_DEF) ? dmbtc_pkg::MAX_RUN_DEF : c});
        if (recent_fills.size() > 12) void'(recent_fills.pop_front());
      end else begin
        f = dmbtc_pkg::FUNC_LOOKUP;
        if (recent_fills.size() != 0 && $urandom_range(0, 99) < 60) begin
          pick = recent_fills[$urandom_range(0, recent_fills.size() - 1)];
          off = $urandom_range(0, pick.count);
          s = blk_t'((pick.start + off) & BLOCK_MASK);
          c = $urandom_range(0, pick.count - off) + ($urandom_range(0, 9) == 0);
        end
      end
      issue_request(f, s, c[dmbtc_pkg::COUNT_W-1:0], 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tready_hold > 0) begin
        out_tready <= 1'b0;
        tready_hold--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Response checker: each response taken is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_responses.size() == 0) begin
        $error("response with no request outstanding: tdata %h", out_tdata);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        if (out_tdata[0] !== want.all_present) begin
          $error("all_present: expected %0d, got %0d", want.all_present, out_tdata[0]);
          errors++;
        end
        if (out_tdata[dmbtc_pkg::FIRST_W:1] !== want.first_slot) begin
          $error("first_slot: expected %0d, got %0d", want.first_slot,
                 out_tdata[dmbtc_pkg::FIRST_W:1]);
          errors++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #20000000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    logic [dmbtc_pkg::CFG_W-1:0] phase_slots [N_PHASES];
    response_t                   typed_in;
    errors = 0;
    tready_hold = 0;
    in_idle_pct = 25;
    out_idle_pct = 78;
    slot_setting = dmbtc_pkg::CFG_RESET;
    for (int i = 0; i < dmbtc_pkg::MAX_SLOTS_DEF; i++) tag_valid[i] = 1'b0;
    phase_slots = '{11'd256, 11'd1024, 11'd1, 11'd7, 11'd0, 11'd1023,
                    11'd2047, 11'd100, 11'd0, 11'd3, 11'd512, 11'd0};
    phase_slots[8]  = cfg_t'($urandom_range(2, dmbtc_pkg::MAX_SLOTS_DEF));
    phase_slots[11] = cfg_t'($urandom_range(2, dmbtc_pkg::MAX_SLOTS_DEF));

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= dmbtc_pkg::FUNC_LOOKUP;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, every request kind and each special case.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_cfg) write_slot_count(directed_rows[i].cfg);
      typed_in.all_present = directed_rows[i].exp_present;
      typed_in.first_slot  = directed_rows[i].exp_first;
      issue_request(directed_rows[i].func, directed_rows[i].start, directed_rows[i].count,
                    directed_rows[i].fixed, typed_in);
    end

    // Random part: sender busy / receiver stalling, then swapped, then
    // full rate. Phases 1 and 9 also hold the receiver off for a long
    // stretch so that the engine backs up and stalls its request side.
    for (int p = 0; p < N_PHASES; p++) begin
      write_slot_count(phase_slots[p]);
      in_idle_pct  = (p < 4) ? 25 : (p < 8) ? 78 : 0;
      out_idle_pct = (p < 4) ? 78 : (p < 8) ? 25 : 0;
      run_random_phase(PHASE_REQS, (p == 1 || p == 9) ? 60 : -1);
    end

    wait_for_responses();
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
